@@ hdl/ssi_pkg.sv @@
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared widths, function codes and controller/datapath signal groups for the
// sorted set intersection block.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int unsigned SSI_DEPTH  = 32;
  localparam int unsigned SSI_VAL_W  = 32;
  localparam int unsigned SSI_FUNC_W = 2;

  localparam logic [SSI_FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [SSI_FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [SSI_FUNC_W-1:0] FUNC_RUN    = 2'd2;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic step;
    logic finish;
  } ssi_cmd_t;

  typedef struct packed {
    logic done;
    logic eq;
    logic pend_valid;
    logic can_push;
  } ssi_status_t;

endpackage

@@ hdl/sorted_set_intersection_top.sv @@
// ----------------------------------------------------------------------------
// sorted_set_intersection_top
// Loads two sorted lists and streams their multiset intersection on a run.
// ----------------------------------------------------------------------------
// Loads are taken back to back. A run holds off the input while it merges:
// each merge step is a registered store read (READ) then a compare (CMP),
// at most 2*DEPTH-1 steps, and a last read and the FIN state flag the final
// result. Each match is held until the next one or the end of the run, then
// leaves through an output register; a full output register stalls the merge.
// Reset clears the fill counts and control; the stores are not cleared.
// ----------------------------------------------------------------------------
module sorted_set_intersection_top #(
  parameter int unsigned DEPTH = ssi_pkg::SSI_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] common_value
  output logic        m_axis_tuser,   // [0] has_value
  output logic        m_axis_tlast
);

  import ssi_pkg::*;

  ssi_cmd_t    cmd;
  ssi_status_t status;

  ssi_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .func_i   (s_axis_tuser),
    .s_ready_o(s_axis_tready),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ssi_dp #(.DEPTH(DEPTH)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .value_i  (s_axis_tdata),
    .cmd_i    (cmd),
    .status_o (status),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_value_o(m_axis_tdata),
    .m_has_o  (m_axis_tuser),
    .m_last_o (m_axis_tlast)
  );

endmodule

@@ hdl/ssi_ram.sv @@
// ----------------------------------------------------------------------------
// ssi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ssi_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssi_ctrl
// Controller: accepts load and run items and sequences the two-pointer merge.
// ----------------------------------------------------------------------------
module ssi_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_valid_i,
  input  logic [ssi_pkg::SSI_FUNC_W-1:0]   func_i,
  output logic                             s_ready_o,
  input  ssi_pkg::ssi_status_t             status_i,
  output ssi_pkg::ssi_cmd_t                cmd_o
);

  import ssi_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign s_ready_o = (state_q == ST_IDLE);
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_LOAD_A: cmd_o.load_a = 1'b1;
            FUNC_LOAD_B: cmd_o.load_b = 1'b1;
            FUNC_RUN: begin
              cmd_o.start = 1'b1;
              state_d     = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        state_d = status_i.done ? ST_FIN : ST_CMP;
      end
      ST_CMP: begin
        if (!(status_i.eq && status_i.pend_valid && !status_i.can_push)) begin
          cmd_o.step = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_FIN: begin
        if (status_i.can_push) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/ssi_dp.sv @@
// ----------------------------------------------------------------------------
// ssi_dp
// Datapath: list stores, fill counts, merge pointers, pending match and the
// output register.
// ----------------------------------------------------------------------------
module ssi_dp #(
  parameter int unsigned DEPTH = ssi_pkg::SSI_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ssi_pkg::SSI_VAL_W-1:0]   value_i,
  input  ssi_pkg::ssi_cmd_t               cmd_i,
  output ssi_pkg::ssi_status_t            status_o,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output logic [ssi_pkg::SSI_VAL_W-1:0]   m_value_o,
  output logic                            m_has_o,
  output logic                            m_last_o
);

  import ssi_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [CW-1:0]        count_a_q, count_b_q, idx_a_q, idx_b_q;
  logic [SSI_VAL_W-1:0] head_a, head_b, pend_value_q, m_value_q;
  logic                 pend_valid_q, m_valid_q, m_has_q, m_last_q;
  logic                 we_a, we_b, eq, lt, push, can_push;

  assign we_a = cmd_i.load_a && (count_a_q < DEPTH_C);
  assign we_b = cmd_i.load_b && (count_b_q < DEPTH_C);

  ssi_ram #(.WIDTH(SSI_VAL_W), .DEPTH(DEPTH)) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (we_a),
    .waddr_i(count_a_q[AW-1:0]),
    .wdata_i(value_i),
    .raddr_i(idx_a_q[AW-1:0]),
    .rdata_o(head_a)
  );

  ssi_ram #(.WIDTH(SSI_VAL_W), .DEPTH(DEPTH)) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (we_b),
    .waddr_i(count_b_q[AW-1:0]),
    .wdata_i(value_i),
    .raddr_i(idx_b_q[AW-1:0]),
    .rdata_o(head_b)
  );

  assign eq       = (head_a == head_b);
  assign lt       = ($signed(head_a) < $signed(head_b));
  assign can_push = !m_valid_q || m_ready_i;
  assign push     = (cmd_i.step && eq && pend_valid_q) || cmd_i.finish;

  assign status_o.done       = (idx_a_q >= count_a_q) || (idx_b_q >= count_b_q);
  assign status_o.eq         = eq;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.can_push   = can_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q    <= '0;
      count_b_q    <= '0;
      idx_a_q      <= '0;
      idx_b_q      <= '0;
      pend_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      if (we_a) count_a_q <= count_a_q + 1'b1;
      if (we_b) count_b_q <= count_b_q + 1'b1;
      if (cmd_i.start) begin
        idx_a_q      <= '0;
        idx_b_q      <= '0;
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.step) begin
        if (eq) begin
          idx_a_q      <= idx_a_q + 1'b1;
          idx_b_q      <= idx_b_q + 1'b1;
          pend_valid_q <= 1'b1;
        end else if (lt) begin
          idx_a_q <= idx_a_q + 1'b1;
        end else begin
          idx_b_q <= idx_b_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        count_a_q    <= '0;
        count_b_q    <= '0;
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && eq) begin
      pend_value_q <= head_a;
    end
    if (push) begin
      m_value_q <= (cmd_i.finish && !pend_valid_q) ? '0 : pend_value_q;
      m_has_q   <= cmd_i.finish ? pend_valid_q : 1'b1;
      m_last_q  <= cmd_i.finish;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_value_o = m_value_q;
  assign m_has_o   = m_has_q;
  assign m_last_o  = m_last_q;

endmodule

@@ verif/sorted_set_intersection_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_intersection_top_test
// Self-checking bench for the sorted set intersection block. A directed table
// covers empty runs, signed extremes, duplicates, unsorted lists and the
// unused selector. Random sorted lists follow, some overfilled or shuffled,
// with random gaps on both streams, a long output stall and a drain pause.
// Every result is compared against its table entry or a merge predictor.
// ----------------------------------------------------------------------------
module sorted_set_intersection_top_test;
  import ssi_pkg::*;

  localparam logic [SSI_FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int unsigned ITEM_TARGET = 380;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 4 * SSI_DEPTH + 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [SSI_VAL_W-1:0] value;
    logic                 has;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [SSI_FUNC_W-1:0] func;
    logic [SSI_VAL_W-1:0]  value;
    logic                  typed;
    result_t               want;
  } row_t;

  localparam result_t NO_MATCH = '{value: '0, has: 1'b0, last: 1'b1};
  localparam result_t UNTYPED  = '0;

  localparam row_t DIR_TAB [0:24] = '{
    '{FUNC_RUN,    32'h0000_0000, 1'b1, NO_MATCH},
    '{FUNC_LOAD_B, 32'h0000_0005, 1'b0, UNTYPED},
    '{FUNC_RUN,    32'hFFFF_FFFF, 1'b1, NO_MATCH},
    '{FUNC_LOAD_A, 32'h8000_0000, 1'b0, UNTYPED},
    '{FUNC_LOAD_A, 32'hFFFF_FFFF, 1'b0, UNTYPED},
    '{FUNC_LOAD_A, 32'h0000_0000, 1'b0, UNTYPED},
    '{FUNC_LOAD_A, 32'h7FFF_FFFF, 1'b0, UNTYPED},
    '{FUNC_LOAD_B, 32'h8000_0000, 1'b0, UNTYPED},
    '{FUNC_LOAD_B, 32'h0000_0000, 1'b0, UNTYPED},
    '{FUNC_LOAD_B, 32'h7FFF_FFFF, 1'b0, UNTYPED},
    '{FUNC_RUN,    32'h5555_AAAA, 1'b0, UNTYPED},
    '{FUNC_NONE,   32'hFFFF_FFFF, 1'b0, UNTYPED},
    '{FUNC_LOAD_A, 32'h0000_0001, 1'b0, UNTYPED},
    '{FUNC_LOAD_B, 32'h0000_0002, 1'b0, UNTYPED},
    '{FUNC_RUN,    32'hAAAA_5555, 1'b1, NO_MATCH},
    '{FUNC_LOAD_A, 32'h0000_0007, 1'b0, UNTYPED},
    '{FUNC_LOAD_A, 32'h0000_0003, 1'b0, UNTYPED},
    '{FUNC_LOAD_B, 32'h0000_0003, 1'b0, UNTYPED},
    '{FUNC_LOAD_B, 32'h0000_0007, 1'b0, UNTYPED},
    '{FUNC_RUN,    32'h0000_0000, 1'b0, UNTYPED},
    '{FUNC_LOAD_A, 32'h0000_0004, 1'b0, UNTYPED},
    '{FUNC_LOAD_A, 32'h0000_0004, 1'b0, UNTYPED},
    '{FUNC_LOAD_B, 32'h0000_0004, 1'b0, UNTYPED},
    '{FUNC_RUN,    32'h0000_0000, 1'b0, UNTYPED},
    '{FUNC_RUN,    32'h0000_0000, 1'b1, NO_MATCH}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SSI_VAL_W-1:0]  s_axis_tdata = '0;
  logic [SSI_FUNC_W-1:0] s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [SSI_VAL_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  sorted_set_intersection_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // merge predictor state
  logic [SSI_VAL_W-1:0] list_a_mdl [SSI_DEPTH];
  logic [SSI_VAL_W-1:0] list_b_mdl [SSI_DEPTH];
  int unsigned          fill_a;
  int unsigned          fill_b;

  result_t     common_due_q [$];
  result_t     got;
  result_t     want;
  int unsigned n_items;
  int unsigned n_runs;
  int unsigned n_results;
  int unsigned n_dropped;
  int unsigned n_errors;
  int unsigned idle_cycles;
  bit          rx_hold_req;
  bit          no_idle;

  // append one expected result at the tail
  function automatic void queue_result(input result_t r);
    common_due_q = {common_due_q, r};
  endfunction

  function automatic void merge_predict(input logic [SSI_FUNC_W-1:0] f,
                                        input logic [SSI_VAL_W-1:0] v, input bit record);
    int unsigned i;
    int unsigned j;
    bit          found;
    result_t     prev;
    case (f)
      FUNC_LOAD_A: begin
        if (fill_a < SSI_DEPTH) begin
          list_a_mdl[fill_a] = v;
          fill_a++;
        end else begin
          n_dropped++;
        end
      end
      FUNC_LOAD_B: begin
        if (fill_b < SSI_DEPTH) begin
          list_b_mdl[fill_b] = v;
          fill_b++;
        end else begin
          n_dropped++;
        end
      end
      FUNC_RUN: begin
        i = 0;
        j = 0;
        found = 1'b0;
        prev = '0;
        while (i < fill_a && j < fill_b) begin
          if (list_a_mdl[i] == list_b_mdl[j]) begin
            if (found && record) queue_result(prev);
            prev = '{value: list_a_mdl[i], has: 1'b1, last: 1'b0};
            found = 1'b1;
            i++;
            j++;
          end else if ($signed(list_a_mdl[i]) < $signed(list_b_mdl[j])) begin
            i++;
          end else begin
            j++;
          end
        end
        if (record) begin
          if (found) begin
            prev.last = 1'b1;
            queue_result(prev);
          end else begin
            queue_result(NO_MATCH);
          end
        end
        fill_a = 0;
        fill_b = 0;
        n_runs++;
      end
      default: ;
    endcase
  endfunction

  // offer one item after a random gap, wait for its handshake, then predict
  task automatic offer_item(input logic [SSI_FUNC_W-1:0] f, input logic [SSI_VAL_W-1:0] v,
                            input bit typed, input result_t typed_want);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    merge_predict(f, v, !typed);
    if (typed) queue_result(typed_want);
    if (f != FUNC_NONE) n_items++;
  endtask

  function automatic int unsigned pick_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(0, 8);
    if (roll < 93) return $urandom_range(9, 31);
    return $urandom_range(32, 40);
  endfunction

  // two lists grown from a shared base so that they overlap, or random values, loaded interleaved
  task automatic load_and_run();
    logic [SSI_VAL_W-1:0] a_vals [40];
    logic [SSI_VAL_W-1:0] b_vals [40];
    logic [SSI_VAL_W-1:0] cur;
    logic [SSI_VAL_W-1:0] base;
    int unsigned          na;
    int unsigned          nb;
    int unsigned          ia;
    int unsigned          ib;
    bit                   broken;
    na = pick_len();
    nb = pick_len();
    broken = ($urandom_range(0, 99) < 12);
    base = $urandom();
    cur = base;
    for (int k = 0; k < na; k++) begin
      cur = cur + $urandom_range(0, 3);
      a_vals[k] = broken ? $urandom() : cur;
    end
    cur = base + $urandom_range(0, 4);
    for (int k = 0; k < nb; k++) begin
      cur = cur + $urandom_range(0, 3);
      b_vals[k] = broken ? $urandom() : cur;
    end
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if ($urandom_range(0, 99) < 4) offer_item(FUNC_NONE, $urandom(), 1'b0, UNTYPED);
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
        offer_item(FUNC_LOAD_A, a_vals[ia], 1'b0, UNTYPED);
        ia++;
      end else begin
        offer_item(FUNC_LOAD_B, b_vals[ib], 1'b0, UNTYPED);
        ib++;
      end
    end
    offer_item(FUNC_RUN, $urandom(), 1'b0, UNTYPED);
  endtask

  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      got = '{value: m_axis_tdata, has: m_axis_tuser, last: m_axis_tlast};
      if (common_due_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result: value=%0d has=%0b last=%0b",
                   $signed(got.value), got.has, got.last);
      end else begin
        want = common_due_q.pop_front();
        if (got.value !== want.value || got.has !== want.has || got.last !== want.last) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp %0d/%0b/%0b, got %0d/%0b/%0b (value/has/last)",
                     $signed(want.value), want.has, want.last,
                     $signed(got.value), got.has, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned seq_no;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < $size(DIR_TAB); k++)
      offer_item(DIR_TAB[k].func, DIR_TAB[k].value, DIR_TAB[k].typed, DIR_TAB[k].want);
    seq_no = 0;
    while (n_items < ITEM_TARGET) begin
      if (seq_no == 4) rx_hold_req = 1'b1;
      if (seq_no == 12) begin
        s_axis_tvalid <= 1'b0;
        while (common_due_q.size() != 0) @(posedge clk_i);
      end
      no_idle = (seq_no >= 18 && seq_no < 24);
      load_and_run();
      seq_no++;
    end
    s_axis_tvalid <= 1'b0;
    while (common_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d items over %0d runs, %0d results checked, %0d loads dropped.",
             n_items, n_runs, n_results, n_dropped);
    $display("Mismatching or stray results: %0d.", n_errors);
    if (n_errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
